// ----- rtl/armd_pkg.sv -----
// armd_pkg: shared types and codes for the address range map decoder
// no dependencies; imported by the table, the compare unit and the top level
package armd_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned TargetW = 8;
  localparam int unsigned KindW   = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned SlotOutW = 4;

  localparam logic [KindW-1:0] KIND_ADD   = 2'd0;
  localparam logic [KindW-1:0] KIND_READ  = 2'd1;
  localparam logic [KindW-1:0] KIND_WRITE = 2'd2;

  localparam logic [StatusW-1:0] STAT_OK        = 2'd0;
  localparam logic [StatusW-1:0] STAT_FULL      = 2'd1;
  localparam logic [StatusW-1:0] STAT_NOT_FOUND = 2'd2;

  // one mapping as stored in the table
  typedef struct packed {
    logic [AddrW-1:0]   base;
    logic [AddrW-1:0]   length;
    logic [TargetW-1:0] target;
  } armd_entry_t;

endpackage

// ----- rtl/armd_table.sv -----
// armd_table: mapping store, one write port and one registered read port
// depends on armd_pkg for the entry type
module armd_table import armd_pkg::*; #(
  parameter int unsigned MAP_SLOTS = 16,
  parameter int unsigned IdxW = (MAP_SLOTS > 1) ? $clog2(MAP_SLOTS) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [IdxW-1:0]   wr_addr_i,
  input  armd_entry_t       wr_data_i,
  input  logic              rd_en_i,
  input  logic [IdxW-1:0]   rd_addr_i,
  output armd_entry_t       rd_data_o
);

  armd_entry_t mem_q [MAP_SLOTS];
  armd_entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ----- rtl/armd_cmp.sv -----
// armd_cmp: shared range check, base <= address < base + length in 33 bits
// depends on armd_pkg for the entry type
module armd_cmp import armd_pkg::*; (
  input  armd_entry_t        entry_i,
  input  logic [AddrW-1:0]   address_i,
  output logic               hit_o
);

  logic [AddrW:0] end_addr;

  // carry bit keeps a region ending at the top of the space from wrapping
  assign end_addr = {1'b0, entry_i.base} + {1'b0, entry_i.length};
  assign hit_o    = (entry_i.base <= address_i) && (end_addr > {1'b0, address_i});

endmodule

// ----- rtl/address_range_map_decoder.sv -----
// Address range map decoder: table of up to MAP_SLOTS (base, length, target)
// mappings filled in order, searched lowest slot first.
// Input: a word is taken at a clock edge where start_i is high and busy_o low.
//   kind_i 0 adds a mapping (address_i = base), 1 and 2 look up address_i.
// Output: one result word per input word, shown for one cycle with done_o high;
//   the receiver cannot stall, so the result must be taken in that cycle.
// An add or an unused kind gives its result in the cycle after it is
//   taken and never raises busy_o, so words can follow back to back.
// A lookup walks the filled slots one per cycle through the single table read
//   port and the shared range compare: each read is registered and compared
//   while the next slot is read; the result shows on the first hit or after
//   the last filled slot misses. busy_o stays high until the cycle it appears.
// Slots fill strictly in order and are never removed, so a fill count stands
//   for the valid bits. Reset empties the table at once; no clearing pass.
// slot_index_o carries the low four bits of the slot number.
module address_range_map_decoder import armd_pkg::*; #(
  parameter int unsigned MAP_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [KindW-1:0]    kind_i,
  input  logic [AddrW-1:0]    address_i,
  input  logic [AddrW-1:0]    region_length_i,
  input  logic [TargetW-1:0]  target_id_i,
  output logic                done_o,
  output logic [StatusW-1:0]  status_o,
  output logic [SlotOutW-1:0] slot_index_o,
  output logic [TargetW-1:0]  hit_target_o,
  output logic                is_write_o
);

  localparam int unsigned IdxW = (MAP_SLOTS > 1) ? $clog2(MAP_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(MAP_SLOTS + 1);
  localparam logic [CntW-1:0] SlotCnt = CntW'(MAP_SLOTS);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e               state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      idx_q, idx_d;
  logic                 pend_q, pend_d;
  logic [IdxW-1:0]      pend_idx_q, pend_idx_d;
  logic [AddrW-1:0]     addr_q, addr_d;
  logic                 wr_flag_q, wr_flag_d;

  logic                 done_q, done_d;
  logic [StatusW-1:0]   status_q, status_d;
  logic [SlotOutW-1:0]  slot_q, slot_d;
  logic [TargetW-1:0]   target_q, target_d;
  logic                 is_write_q, is_write_d;

  logic                 wr_en;
  logic                 rd_en;
  armd_entry_t          wr_entry;
  armd_entry_t          rd_entry;
  logic                 hit;
  logic [IdxW+SlotOutW-1:0] count_ext;
  logic [IdxW+SlotOutW-1:0] pend_ext;

  assign wr_entry  = '{base: address_i, length: region_length_i, target: target_id_i};
  assign count_ext = {{SlotOutW{1'b0}}, count_q[IdxW-1:0]};
  assign pend_ext  = {{SlotOutW{1'b0}}, pend_idx_q};

  armd_table #(
    .MAP_SLOTS (MAP_SLOTS),
    .IdxW      (IdxW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[IdxW-1:0]),
    .wr_data_i (wr_entry),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q[IdxW-1:0]),
    .rd_data_o (rd_entry)
  );

  armd_cmp u_cmp (
    .entry_i   (rd_entry),
    .address_i (addr_q),
    .hit_o     (hit)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    addr_d     = addr_q;
    wr_flag_d  = wr_flag_q;
    done_d     = 1'b0;
    status_d   = status_q;
    slot_d     = slot_q;
    target_d   = target_q;
    is_write_d = is_write_q;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (kind_i)
            KIND_ADD: begin
              done_d     = 1'b1;
              target_d   = '0;
              is_write_d = 1'b0;
              if (count_q < SlotCnt) begin
                wr_en    = 1'b1;
                count_d  = count_q + 1'b1;
                status_d = STAT_OK;
                slot_d   = count_ext[SlotOutW-1:0];
              end else begin
                status_d = STAT_FULL;
                slot_d   = '0;
              end
            end
            KIND_READ, KIND_WRITE: begin
              state_d   = S_SCAN;
              idx_d     = '0;
              addr_d    = address_i;
              wr_flag_d = (kind_i == KIND_WRITE);
            end
            default: begin
              done_d     = 1'b1;
              status_d   = STAT_NOT_FOUND;
              slot_d     = '0;
              target_d   = '0;
              is_write_d = 1'b0;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (pend_q && hit) begin
          done_d     = 1'b1;
          status_d   = STAT_OK;
          slot_d     = pend_ext[SlotOutW-1:0];
          target_d   = rd_entry.target;
          is_write_d = wr_flag_q;
          state_d    = S_IDLE;
        end else if (idx_q < count_q) begin
          // read this slot now, its compare happens next cycle
          rd_en      = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = idx_q[IdxW-1:0];
          idx_d      = idx_q + 1'b1;
        end else begin
          done_d     = 1'b1;
          status_d   = STAT_NOT_FOUND;
          slot_d     = '0;
          target_d   = '0;
          is_write_d = wr_flag_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    addr_q     <= addr_d;
    wr_flag_q  <= wr_flag_d;
    status_q   <= status_d;
    slot_q     <= slot_d;
    target_q   <= target_d;
    is_write_q <= is_write_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign slot_index_o = slot_q;
  assign hit_target_o = target_q;
  assign is_write_o   = is_write_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SlotCnt)
    else $error("fill count beyond table size");

  a_access_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (kind_i == KIND_READ || kind_i == KIND_WRITE)) |=> busy_o)
    else $error("lookup taken without entering scan");

  a_count_stable_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> $stable(count_q))
    else $error("table fill changed during a lookup");

  a_scan_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> idx_q <= count_q)
    else $error("scan index past filled slots");

  a_miss_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STAT_OK) |-> (slot_index_o == '0 && hit_target_o == '0))
    else $error("failed result carries slot or target");

endmodule
